>>> hw/rtl/lphm_pkg.sv
// shared types, codes and the key mixing function of the linear probe hash map
// no dependencies
package lphm_pkg;

	localparam int DATA_W        = 64;
	localparam int CNT_W         = 11;
	localparam int MARK_W        = 2;
	localparam int ENTRY_W       = MARK_W + 2 * DATA_W;
	localparam int SLOTS_DEFAULT = 1024;
	localparam int CFG_ADDR_W    = 3;
	localparam int APB_DATA_W    = 32;

	localparam logic [CNT_W-1:0] MAX_LIVE_RESET = 11'd716;

	// register indexes
	localparam logic REG_MAX_LIVE = 1'b0;

	// slot marks
	localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
	localparam logic [MARK_W-1:0] MARK_LIVE  = 2'd1;
	localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

	// request opcodes
	localparam logic [1:0] CMD_PUT    = 2'd0;
	localparam logic [1:0] CMD_GET    = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;

	localparam logic [1:0] HASH_ROUND_LAST = 2'd3;

	typedef struct packed {
		logic clr;
		logic load;
		logic hash;
		logic home;
		logic probe;
	} lphm_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic hash_last;
		logic probe_stop;
	} lphm_stat_t;

	// one round of the integer mix, two of the seven original steps per round, the last round one
	function automatic logic [DATA_W-1:0] mix_round(input logic [DATA_W-1:0] k,
			input logic [1:0] rnd);
		logic [DATA_W-1:0] t;
		logic [DATA_W-1:0] r;
		case (rnd)
			2'd0: begin
				t = ~k + (k << 21);
				r = t ^ (t >> 24);
			end
			2'd1: begin
				t = k + (k << 3) + (k << 8);
				r = t ^ (t >> 14);
			end
			2'd2: begin
				t = k + (k << 2) + (k << 4);
				r = t ^ (t >> 28);
			end
			default: begin
				t = k;
				r = t + (t << 31);
			end
		endcase
		return r;
	endfunction

endpackage

>>> hw/rtl/linear_probe_hash_map.sv
// top level of the linear probe hash map: apb register, controller and datapath
// depends on lphm_pkg, lphm_ctrl, lphm_dp, lphm_ram
// A request (put, get or remove) is taken when start is high and busy is low. The key is
// mixed in the hash rounds, the home state issues the home slot read, then the walk checks
// one slot per cycle through the single read port of the slot ram until it meets the key,
// an empty slot, or has seen every slot. The result shows on done for exactly one cycle, in
// the cycle after the last slot checked, and cannot be held off; busy is already low there,
// so the next request may start in that cycle. After reset the slot marks are cleared one
// slot per cycle with busy high; max_live may be written during that time.
module linear_probe_hash_map #(
	parameter int SLOTS = lphm_pkg::SLOTS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lphm_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [lphm_pkg::APB_DATA_W-1:0] pwdata,
	output logic [lphm_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      cmd,
	input  logic signed [lphm_pkg::DATA_W-1:0] key,
	input  logic signed [lphm_pkg::DATA_W-1:0] value_in,
	output logic                            done,
	output logic signed [lphm_pkg::DATA_W-1:0] value_out,
	output logic                            found,
	output logic [lphm_pkg::CNT_W-1:0]      live_count,
	output logic                            status
);

	import lphm_pkg::*;

	logic [CNT_W-1:0]  max_live_q;
	lphm_cmd_t         dp_cmd;
	lphm_stat_t        dp_stat;
	logic [DATA_W-1:0] value_out_raw;
	logic              reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_live_q <= MAX_LIVE_RESET;
		end else if (psel && penable && pwrite && (reg_sel == REG_MAX_LIVE)) begin
			max_live_q <= pwdata[CNT_W-1:0];
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_MAX_LIVE: prdata = {{(APB_DATA_W-CNT_W){1'b0}}, max_live_q};
			default:      prdata = '0;
		endcase
	end

	lphm_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (dp_cmd),
		.stat  (dp_stat)
	);

	lphm_dp #(
		.SLOTS(SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (dp_cmd),
		.stat      (dp_stat),
		.op        (cmd),
		.key       ($unsigned(key)),
		.value_in  ($unsigned(value_in)),
		.max_live  (max_live_q),
		.done      (done),
		.value_out (value_out_raw),
		.found     (found),
		.live_count(live_count),
		.status    (status)
	);

	assign value_out = $signed(value_out_raw);

	// an accepted request always makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after request accept");

	// results come out only once the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// one result per request, never two strobes in a row
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe repeated");

	// refusals only on put, and a refused put never reports a hit
	a_status_found: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> !found)
		else $error("refused put reported as found");

endmodule

>>> hw/rtl/lphm_ram.sv
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
module lphm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/lphm_ctrl.sv
// controller state machine: clearing pass, hashing rounds, probe walk
// depends on lphm_pkg
module lphm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output lphm_pkg::lphm_cmd_t  cmd,
	input  lphm_pkg::lphm_stat_t stat
);

	import lphm_pkg::*;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_HASH  = 5'b00100,
		S_HOME  = 5'b01000,
		S_PROBE = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (stat.clear_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_HASH;
				end
			end
			S_HASH: begin
				cmd.hash = 1'b1;
				if (stat.hash_last) state_d = S_HOME;
			end
			S_HOME: begin
				cmd.home = 1'b1;
				state_d  = S_PROBE;
			end
			S_PROBE: begin
				cmd.probe = 1'b1;
				if (stat.probe_stop) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hw/rtl/lphm_dp.sv
// datapath: key hash, slot table ram, probe compare, live count and result registers
// depends on lphm_pkg and lphm_ram
module lphm_dp #(
	parameter int SLOTS = lphm_pkg::SLOTS_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lphm_pkg::lphm_cmd_t         cmd,
	output lphm_pkg::lphm_stat_t        stat,
	input  logic [1:0]                  op,
	input  logic [lphm_pkg::DATA_W-1:0] key,
	input  logic [lphm_pkg::DATA_W-1:0] value_in,
	input  logic [lphm_pkg::CNT_W-1:0]  max_live,
	output logic                        done,
	output logic [lphm_pkg::DATA_W-1:0] value_out,
	output logic                        found,
	output logic [lphm_pkg::CNT_W-1:0]  live_count,
	output logic                        status
);

	import lphm_pkg::*;

	localparam int IW = $clog2(SLOTS);

	logic [1:0]        op_q;
	logic [DATA_W-1:0] key_q, val_q, hash_q;
	logic [1:0]        rnd_q;
	logic [IW-1:0]     idx_q, probes_q, tomb_idx_q;
	logic              tomb_vld_q;
	logic [CNT_W-1:0]  count_q;
	logic              done_q, found_q, status_q;
	logic [DATA_W-1:0] value_out_q;

	logic               we;
	logic [IW-1:0]      waddr, raddr;
	logic [ENTRY_W-1:0] wdata, rdata;

	logic [MARK_W-1:0] r_mark;
	logic [DATA_W-1:0] r_key, r_val;
	logic is_empty, is_hit, is_tomb, is_last, stop, fin;
	logic have_tomb, target_ok;
	logic [IW-1:0] target;
	logic              f_wr, f_found, f_status;
	logic [IW-1:0]     f_addr;
	logic [ENTRY_W-1:0] f_data;
	logic [DATA_W-1:0] f_value;
	logic [CNT_W-1:0]  f_count;

	assign r_mark = rdata[ENTRY_W-1 -: MARK_W];
	assign r_key  = rdata[2*DATA_W-1 -: DATA_W];
	assign r_val  = rdata[DATA_W-1:0];

	assign is_empty  = (r_mark == MARK_EMPTY);
	assign is_hit    = (r_mark == MARK_LIVE) && (r_key == key_q);
	assign is_tomb   = (r_mark == MARK_TOMB);
	assign is_last   = (probes_q == {IW{1'b1}});
	assign stop      = is_empty | is_hit | is_last;
	assign fin       = cmd.probe & stop;
	assign have_tomb = tomb_vld_q | is_tomb;
	assign target_ok = have_tomb | is_empty;
	assign target    = tomb_vld_q ? tomb_idx_q : idx_q;

	// outcome of the request once the probe walk stops
	always_comb begin
		f_wr     = 1'b0;
		f_addr   = idx_q;
		f_data   = {MARK_LIVE, key_q, val_q};
		f_found  = 1'b0;
		f_status = 1'b0;
		f_value  = '0;
		f_count  = count_q;
		case (op_q)
			CMD_PUT: begin
				if (is_hit) begin
					f_wr    = 1'b1;
					f_found = 1'b1;
				end else if ((count_q >= max_live) || !target_ok) begin
					f_status = 1'b1;
				end else begin
					f_wr    = 1'b1;
					f_addr  = target;
					f_count = count_q + 11'd1;
				end
			end
			CMD_GET: begin
				if (is_hit) begin
					f_value = r_val;
					f_found = 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (is_hit) begin
					f_wr    = 1'b1;
					f_data  = {MARK_TOMB, r_key, r_val};
					f_found = 1'b1;
					if (count_q != '0) f_count = count_q - 11'd1;
				end
			end
			default: ;
		endcase
	end

	assign we    = cmd.clr | (fin & f_wr);
	assign waddr = cmd.clr ? idx_q : f_addr;
	assign wdata = cmd.clr ? {MARK_EMPTY, {(2*DATA_W){1'b0}}} : f_data;
	// the read runs one slot ahead so the walk checks one slot per cycle
	assign raddr = cmd.home ? hash_q[IW-1:0] : IW'(idx_q + 1'b1);

	lphm_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOTS)
	) u_slots (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign stat.clear_last = (idx_q == {IW{1'b1}});
	assign stat.hash_last  = (rnd_q == HASH_ROUND_LAST);
	assign stat.probe_stop = stop;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op;
			key_q  <= key;
			val_q  <= value_in;
			hash_q <= key;
		end else if (cmd.hash) begin
			hash_q <= mix_round(hash_q, rnd_q);
		end
		if (cmd.home) begin
			probes_q <= '0;
		end else if (cmd.probe) begin
			probes_q <= IW'(probes_q + 1'b1);
			if (is_tomb && !tomb_vld_q) tomb_idx_q <= idx_q;
		end
		if (fin) begin
			value_out_q <= f_value;
			found_q     <= f_found;
			status_q    <= f_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			rnd_q      <= '0;
			tomb_vld_q <= 1'b0;
			count_q    <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= fin;
			if (cmd.load) rnd_q <= '0;
			else if (cmd.hash) rnd_q <= rnd_q + 2'd1;
			if (cmd.clr) begin
				idx_q <= IW'(idx_q + 1'b1);
			end else if (cmd.home) begin
				idx_q      <= hash_q[IW-1:0];
				tomb_vld_q <= 1'b0;
			end else if (cmd.probe && !stop) begin
				idx_q <= IW'(idx_q + 1'b1);
				if (is_tomb) tomb_vld_q <= 1'b1;
			end
			if (fin) count_q <= f_count;
		end
	end

	assign done       = done_q;
	assign value_out  = value_out_q;
	assign found      = found_q;
	assign status     = status_q;
	assign live_count = count_q;

endmodule
